@@ hw/rtl/gmt_pkg.sv @@
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types and constants of the gradient magnitude threshold block.
// ----------------------------------------------------------------------------
package gmt_pkg;

  localparam int ROOT_BITS = 8;
  localparam logic [ROOT_BITS-1:0] MAG_MAX = 8'd255;
  localparam int ROOT_IN_BITS = 2 * ROOT_BITS;
  localparam int FRAC_SHIFT = 4;
  localparam int COEF_EDGE = 3;
  localparam int COEF_MID = 10;
  localparam int THR_BITS = 9;
  localparam int IMG_W_BITS = 13;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } gmt_root_stat_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_SHIFT0 = 7'b0000100,
    ST_GRAD   = 7'b0001000,
    ST_SQR    = 7'b0010000,
    ST_ROOT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } gmt_state_t;

endpackage

@@ hw/rtl/gmt_ram.sv @@
// ----------------------------------------------------------------------------
// gmt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gmt_root.sv @@
// ----------------------------------------------------------------------------
// gmt_root
// Iterative integer square root, one result bit per cycle, saturating.
// ----------------------------------------------------------------------------
module gmt_root #(
  parameter int VALUE_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_BITS-1:0]          value,
  output gmt_pkg::gmt_root_stat_t        stat,
  output logic [gmt_pkg::ROOT_BITS-1:0]  root
);
  import gmt_pkg::*;

  localparam int BW = $clog2(ROOT_BITS);

  logic [ROOT_IN_BITS-1:0] v;
  logic                    sat;
  logic [ROOT_BITS-1:0]    r;
  logic [ROOT_BITS-1:0]    t;
  logic [ROOT_IN_BITS-1:0] tsq;
  logic [BW-1:0]           b;
  logic                    busy;
  logic                    done;

  assign t    = r | (ROOT_BITS'(1) << b);
  assign tsq  = ROOT_IN_BITS'(t) * ROOT_IN_BITS'(t);
  assign root = sat ? MAG_MAX : r;
  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= value[ROOT_IN_BITS-1:0];
        sat  <= |value[VALUE_BITS-1:ROOT_IN_BITS];
        r    <= '0;
        b    <= BW'(ROOT_BITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (tsq <= v) begin
          r <= t;
        end
        if (b == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        b <= b - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/gradient_magnitude_threshold.sv @@
// ----------------------------------------------------------------------------
// gradient_magnitude_threshold
// Streaming 3x3 Scharr-type gradient magnitude with threshold.
// ----------------------------------------------------------------------------
// Input channel: pixel, frame_start, pad_row with in_valid/in_stall. Pixels
// arrive in raster order; the feeder appends one padding row (pad_row high).
// Output channel: edge_value, row_end with out_valid/out_stall; each result
// is the thresholded magnitude of the center one row above and one column
// left of the input pixel (for the row-end result, in its own column).
// Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data; always ready.
// The user must write it only while the block is idle; the block does not
// enforce this. Both previous rows live in one RAM entry per column, read
// at accept and written back in the cycle after. An item gives no, one or
// two results; each result passes gradient, square, bit-serial square root
// and output load, and the row-end result first takes a window shift. A
// stalled receiver holds the output register and the block waits in its
// output state. Reset clears counters, window, registers (threshold 0,
// width 640); line stores need no clearing.
// ----------------------------------------------------------------------------
module gradient_magnitude_threshold #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PIXEL_BITS-1:0]              pixel,
  input  logic                               frame_start,
  input  logic                               pad_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gmt_pkg::ROOT_BITS-1:0]      edge_value,
  output logic                               row_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gmt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [gmt_pkg::IMG_W_BITS-1:0]     cfg_data
);
  import gmt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = PIXEL_BITS + 6;
  localparam int VB = 2 * PIXEL_BITS + 1;

  gmt_state_t state;

  logic [THR_BITS-1:0]   threshold_level;
  logic [IMG_W_BITS-1:0] image_width;
  logic [CW-1:0]         column_count;
  logic [1:0]            rows_seen;

  logic [PIXEL_BITS-1:0] win [3][3];

  logic [CW-1:0]         colr;
  logic                  clr_win;
  logic [1:0]            rows_eff;
  logic [PIXEL_BITS-1:0] pixr;
  logic                  need1;
  logic                  need2;
  logic                  phase;

  logic [PIXEL_BITS-1:0] ax;
  logic [PIXEL_BITS-1:0] ay;

  logic                  accept;
  logic [31:0]           w32;
  logic [CW-1:0]         wm1;
  logic [1:0]            rows_in;
  logic [CW-1:0]         cc_in;
  logic [CW-1:0]         col;
  logic                  last;

  logic [2*PIXEL_BITS-1:0] rdata;
  logic [PIXEL_BITS-1:0]   top;
  logic [PIXEL_BITS-1:0]   mid;

  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [SW-1:0] gx;
  logic signed [SW-1:0] gy;
  logic [SW-1:0]        axw;
  logic [SW-1:0]        ayw;
  logic [VB-1:0]        sum;

  gmt_root_stat_t       rstat;
  logic [ROOT_BITS-1:0] mag;
  logic                 emit_go;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (image_width == '0) begin
      w32 = 32'd1;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = 32'(image_width);
    end
    wm1     = CW'(w32 - 32'd1);
    rows_in = frame_start ? 2'd0 : rows_seen;
    cc_in   = frame_start ? '0 : column_count;
    col     = (cc_in > wm1) ? wm1 : cc_in;
    last    = (col == wm1);
  end

  gmt_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (state == ST_LOAD),
    .waddr(colr),
    .wdata({rdata[PIXEL_BITS-1:0], pixr}),
    .raddr(col),
    .rdata(rdata)
  );

  assign top = (rows_eff >= 2'd2) ? rdata[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
  assign mid = (rows_eff >= 2'd1) ? rdata[PIXEL_BITS-1:0] : '0;

  function automatic logic signed [SW-1:0] ext(input logic [PIXEL_BITS-1:0] p);
    ext = $signed(SW'(p));
  endfunction

  always_comb begin
    sx  = SW'(COEF_EDGE) * (ext(win[0][2]) - ext(win[0][0]))
        + SW'(COEF_MID)  * (ext(win[1][2]) - ext(win[1][0]))
        + SW'(COEF_EDGE) * (ext(win[2][2]) - ext(win[2][0]));
    sy  = SW'(COEF_EDGE) * (ext(win[2][0]) - ext(win[0][0]))
        + SW'(COEF_MID)  * (ext(win[2][1]) - ext(win[0][1]))
        + SW'(COEF_EDGE) * (ext(win[2][2]) - ext(win[0][2]));
    gx  = (sx < 0) ? ((sx + $signed(SW'(15))) >>> FRAC_SHIFT) : (sx >>> FRAC_SHIFT);
    gy  = (sy < 0) ? ((sy + $signed(SW'(15))) >>> FRAC_SHIFT) : (sy >>> FRAC_SHIFT);
    axw = (gx < 0) ? SW'(-gx) : SW'(gx);
    ayw = (gy < 0) ? SW'(-gy) : SW'(gy);
    sum = VB'(VB'(ax) * VB'(ax)) + VB'(VB'(ay) * VB'(ay));
  end

  gmt_root #(
    .VALUE_BITS(VB)
  ) u_root (
    .clk  (clk),
    .rst  (rst),
    .start(state == ST_SQR),
    .value(sum),
    .stat (rstat),
    .root (mag)
  );

  assign emit_go = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      threshold_level <= '0;
      image_width     <= IMG_W_BITS'(640);
      column_count    <= '0;
      rows_seen       <= 2'd0;
      out_valid       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) begin
          threshold_level <= cfg_data[THR_BITS-1:0];
        end else if (cfg_index == CFG_WIDTH) begin
          image_width <= cfg_data;
        end
      end
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            colr     <= col;
            clr_win  <= frame_start || (col == '0);
            rows_eff <= rows_in;
            pixr     <= pad_row ? '0 : pixel;
            need1    <= (rows_in != 2'd0) && (col != '0);
            need2    <= (rows_in != 2'd0) && last;
            phase    <= 1'b0;
            column_count <= last ? '0 : col + 1'b1;
            rows_seen    <= (last && rows_in != 2'd2) ? rows_in + 2'd1 : rows_in;
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= clr_win ? '0 : win[i][1];
            win[i][1] <= clr_win ? '0 : win[i][2];
          end
          win[0][2] <= top;
          win[1][2] <= mid;
          win[2][2] <= pixr;
          if (need1) begin
            state <= ST_GRAD;
          end else if (need2) begin
            state <= ST_SHIFT0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SHIFT0: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= win[i][1];
            win[i][1] <= win[i][2];
            win[i][2] <= '0;
          end
          phase <= 1'b1;
          state <= ST_GRAD;
        end
        ST_GRAD: begin
          ax    <= axw[PIXEL_BITS-1:0];
          ay    <= ayw[PIXEL_BITS-1:0];
          state <= ST_SQR;
        end
        ST_SQR: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rstat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            edge_value <= ({1'b0, mag} > threshold_level) ? mag : '0;
            row_end    <= phase;
            state      <= (!phase && need2) ? ST_SHIFT0 : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOAD)
    else $error("accepted pixel did not start a line store access");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    rstat.done |-> state == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_root_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> !rstat.busy)
    else $error("result loaded while square root still busy");

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_valid) |=> out_valid)
    else $error("free output register not loaded");

  a_rows_sat: assert property (@(posedge clk) disable iff (rst)
    rows_seen != 2'd3)
    else $error("row count passed saturation");

endmodule
